@@ rtl/bsah_pkg.sv @@
`timescale 1ns / 1ps
// Package for the binned SAH split finder.
// Holds the state machine type, axis codes, field widths and default parameters.
package bsah_pkg;

  localparam int BINS_DEF       = 16;
  localparam int MAX_PRIMS_DEF  = 1024;
  localparam int COORD_BITS_DEF = 16;

  localparam int FIELD_W = 16;
  localparam int COST_W  = 63;
  localparam int AXIS_W  = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_DONE = 2'd3;

  typedef enum logic [4:0] {
    S_LOAD,
    S_BND_RD,
    S_BND_ACC,
    S_AX_START,
    S_CLR,
    S_BIN_RD,
    S_BIN_LD,
    S_BIN_DIV,
    S_BIN_BRD,
    S_BIN_UPD,
    S_SW_RD,
    S_SW_GROW,
    S_SW_MUL,
    S_SW_AREA,
    S_SW_COST,
    S_SW_NEXT,
    S_AX_END,
    S_POS_DIV,
    S_DONE
  } state_t;

endpackage

@@ rtl/binned_sah_split_finder.sv @@
`timescale 1ns / 1ps
// Binned SAH split finder: primitive store, bin store, bucket divider and sweep datapath.
// Depends on bsah_pkg.
//
// channel | signals                                   | direction
// in      | in_valid, in_stall, min/max/cent xyz, ... | one primitive per beat
// out     | out_valid, out_stall, found, split_*      | one result per set
//
// Loading takes one primitive beat per cycle while in_stall is low. The search after the
// last beat walks the primitive memory once for bounds, reading and then accumulating
// each primitive; then per live axis it clears the bins, bins each primitive through the
// bit-serial divider and sweeps the BINS-1 planes once upward and once downward.
// When a split was found, its position then comes from a reciprocal multiply.
// Reset is synchronous and clears control state only; memories need no clearing.
// A finished result waits in the output register; more primitives are taken meanwhile,
// but a beat that ends a set is stalled until that result has gone.
module binned_sah_split_finder #(
  parameter int BINS       = bsah_pkg::BINS_DEF,
  parameter int MAX_PRIMS  = bsah_pkg::MAX_PRIMS_DEF,
  parameter int COORD_BITS = bsah_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [bsah_pkg::FIELD_W-1:0] min_x,
  input  logic signed [bsah_pkg::FIELD_W-1:0] min_y,
  input  logic signed [bsah_pkg::FIELD_W-1:0] min_z,
  input  logic signed [bsah_pkg::FIELD_W-1:0] max_x,
  input  logic signed [bsah_pkg::FIELD_W-1:0] max_y,
  input  logic signed [bsah_pkg::FIELD_W-1:0] max_z,
  input  logic signed [bsah_pkg::FIELD_W-1:0] cent_x,
  input  logic signed [bsah_pkg::FIELD_W-1:0] cent_y,
  input  logic signed [bsah_pkg::FIELD_W-1:0] cent_z,
  input  logic is_last,
  input  logic is_empty_set,
  output logic out_valid,
  input  logic out_stall,
  output logic found,
  output logic [bsah_pkg::AXIS_W-1:0] split_axis,
  output logic [bsah_pkg::COST_W-1:0] split_cost,
  output logic signed [bsah_pkg::FIELD_W-1:0] split_position
);

  localparam int CB   = COORD_BITS;
  localparam int AW   = $clog2(MAX_PRIMS);
  localparam int CW   = $clog2(MAX_PRIMS + 1);
  localparam int BA   = $clog2(BINS);
  localparam int BW   = $clog2(BINS + 1);
  localparam int DW   = CB + BW;
  localparam int DCW  = $clog2(DW + 1);
  localparam int PRW  = 2 * CB;
  localparam int AR   = PRW + 3;
  localparam int PW   = (CW + AR > 64) ? CW + AR : 64;
  localparam int MW   = 9 * CB;
  localparam int BEW  = 6 * CB + CW;

  // Rounded-up reciprocal of BINS; exact floor division for any DW-bit numerator.
  localparam int POS_SH = DW + $clog2(BINS);
  localparam longint unsigned POS_RECIP = ((64'd1 << POS_SH) + 64'(BINS - 1)) / 64'(BINS);

  localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

  bsah_pkg::state_t state, state_next;

  logic in_acc;
  logic [CW-1:0] prim_count, ptr;
  logic [CW-1:0] last_ptr;
  logic [bsah_pkg::AXIS_W-1:0] axis;
  logic [BA-1:0] bidx;
  logic right;

  // Primitive memory.
  logic [MW-1:0] prim_mem [MAX_PRIMS];
  logic [MW-1:0] prim_rd;
  logic [MW-1:0] prim_wdata;

  // Bin memory and left cost memory.
  logic [BEW-1:0] bin_mem [BINS];
  logic [BEW-1:0] bin_rd, bin_wdata;
  logic [BA-1:0] bin_addr;
  logic bin_we;
  logic [bsah_pkg::COST_W-1:0] lc_mem [BINS];
  logic [bsah_pkg::COST_W-1:0] lc_rd;
  logic [BA-1:0] lc_addr;

  logic signed [CB-1:0] pr_min [3];
  logic signed [CB-1:0] pr_max [3];
  logic signed [CB-1:0] pr_cent [3];
  logic signed [CB-1:0] bn_min [3];
  logic signed [CB-1:0] bn_max [3];
  logic [CW-1:0] bn_cnt;

  logic signed [CB-1:0] b_lo [3];
  logic signed [CB-1:0] b_hi [3];
  logic signed [CB-1:0] cur_lo, cur_hi, cur_cent;
  logic [CB-1:0] cur_span;
  logic cur_deg;

  // Restoring divider for the bucket index.
  logic [DW-1:0] div_num, div_quo;
  logic [CB-1:0] div_den, div_rem, rem_next;
  logic [DCW-1:0] div_cnt;
  logic [CB:0] trial;
  logic ge;
  logic [BA-1:0] bin_idx;
  logic [2*DW:0] pos_prod;
  logic [CB-1:0] pos_quo;

  // Sweep datapath.
  logic signed [CB-1:0] acc_lo [3];
  logic signed [CB-1:0] acc_hi [3];
  logic [CW-1:0] n_acc;
  logic [PRW-1:0] prod [3];
  logic neg;
  logic [AR-1:0] area;
  logic [PW-1:0] cst_full;
  logic [bsah_pkg::COST_W-1:0] cst;
  logic [63:0] total_full;
  logic [bsah_pkg::COST_W-1:0] total;

  logic ax_found;
  logic [bsah_pkg::COST_W-1:0] ax_best, best;
  logic [BA-1:0] ax_plane, best_plane;
  logic [bsah_pkg::AXIS_W-1:0] best_axis;
  logic best_found;
  logic signed [CB-1:0] best_lo;
  logic [CB-1:0] best_span;
  logic [CB:0] pos_full;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != bsah_pkg::S_LOAD) || (out_valid && (is_last || is_empty_set));
  assign last_ptr = prim_count - CW'(1);

  assign prim_wdata = {CB'($unsigned(cent_z)), CB'($unsigned(cent_y)), CB'($unsigned(cent_x)),
                       CB'($unsigned(max_z)), CB'($unsigned(max_y)), CB'($unsigned(max_x)),
                       CB'($unsigned(min_z)), CB'($unsigned(min_y)), CB'($unsigned(min_x))};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_min[k]  = prim_rd[k*CB +: CB];
      pr_max[k]  = prim_rd[3*CB + k*CB +: CB];
      pr_cent[k] = prim_rd[6*CB + k*CB +: CB];
      bn_min[k]  = bin_rd[k*CB +: CB];
      bn_max[k]  = bin_rd[3*CB + k*CB +: CB];
    end
    bn_cnt = bin_rd[6*CB +: CW];
  end

  always_comb begin
    unique case (axis)
      bsah_pkg::AXIS_X: begin
        cur_lo = b_lo[0]; cur_hi = b_hi[0]; cur_cent = pr_cent[0];
      end
      bsah_pkg::AXIS_Y: begin
        cur_lo = b_lo[1]; cur_hi = b_hi[1]; cur_cent = pr_cent[1];
      end
      bsah_pkg::AXIS_Z: begin
        cur_lo = b_lo[2]; cur_hi = b_hi[2]; cur_cent = pr_cent[2];
      end
      default: begin
        cur_lo = '0; cur_hi = '0; cur_cent = '0;
      end
    endcase
    cur_span = CB'(cur_hi - cur_lo);
    cur_deg  = (cur_lo == cur_hi);
  end

  assign trial    = {div_rem, div_num[DW-1]};
  assign ge       = trial >= {1'b0, div_den};
  assign rem_next = ge ? CB'(trial - {1'b0, div_den}) : CB'(trial);
  assign bin_idx  = (div_quo >= DW'(BINS)) ? BA'(BINS - 1) : div_quo[BA-1:0];
  assign pos_prod = (2*DW+1)'(div_num) * (2*DW+1)'(POS_RECIP);

  assign cst_full   = PW'(n_acc) * PW'(area);
  assign total_full = {1'b0, lc_rd} + {1'b0, cst};
  assign total      = total_full[63] ? bsah_pkg::COST_MAX : total_full[62:0];
  assign pos_full   = {best_lo[CB-1], best_lo} + {1'b0, pos_quo};

  // Memory ports.
  always_comb begin
    bin_addr  = bidx;
    bin_we    = 1'b0;
    bin_wdata = {CW'(0), {3{C_MIN}}, {3{C_MAX}}};
    if (state == bsah_pkg::S_BIN_BRD || state == bsah_pkg::S_BIN_UPD) begin
      bin_addr = bin_idx;
    end
    if (state == bsah_pkg::S_CLR) begin
      bin_we = 1'b1;
    end else if (state == bsah_pkg::S_BIN_UPD) begin
      bin_we = 1'b1;
      for (int k = 0; k < 3; k++) begin
        bin_wdata[k*CB +: CB]        = (pr_min[k] < bn_min[k]) ? pr_min[k] : bn_min[k];
        bin_wdata[3*CB + k*CB +: CB] = (pr_max[k] > bn_max[k]) ? pr_max[k] : bn_max[k];
      end
      bin_wdata[6*CB +: CW] = bn_cnt + CW'(1);
    end
    lc_addr = bidx - BA'(1);
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_empty_set && prim_count < CW'(MAX_PRIMS)) begin
      prim_mem[prim_count[AW-1:0]] <= prim_wdata;
    end
    prim_rd <= prim_mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_addr] <= bin_wdata;
    end
    bin_rd <= bin_mem[bin_addr];
  end

  always_ff @(posedge clk) begin
    if (state == bsah_pkg::S_SW_NEXT && !right) begin
      lc_mem[bidx] <= cst;
    end
    lc_rd <= lc_mem[lc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsah_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bsah_pkg::S_LOAD: begin
        if (in_acc && !is_empty_set && is_last) state_next = bsah_pkg::S_BND_RD;
      end
      bsah_pkg::S_BND_RD: state_next = bsah_pkg::S_BND_ACC;
      bsah_pkg::S_BND_ACC: begin
        state_next = (ptr == last_ptr) ? bsah_pkg::S_AX_START : bsah_pkg::S_BND_RD;
      end
      bsah_pkg::S_AX_START: begin
        if (axis == bsah_pkg::AXIS_DONE) begin
          state_next = best_found ? bsah_pkg::S_POS_DIV : bsah_pkg::S_DONE;
        end else if (!cur_deg) begin
          state_next = bsah_pkg::S_CLR;
        end
      end
      bsah_pkg::S_CLR: begin
        if (bidx == BA'(BINS - 1)) state_next = bsah_pkg::S_BIN_RD;
      end
      bsah_pkg::S_BIN_RD: state_next = bsah_pkg::S_BIN_LD;
      bsah_pkg::S_BIN_LD: state_next = bsah_pkg::S_BIN_DIV;
      bsah_pkg::S_BIN_DIV: begin
        if (div_cnt == DCW'(1)) state_next = bsah_pkg::S_BIN_BRD;
      end
      bsah_pkg::S_BIN_BRD: state_next = bsah_pkg::S_BIN_UPD;
      bsah_pkg::S_BIN_UPD: begin
        state_next = (ptr == last_ptr) ? bsah_pkg::S_SW_RD : bsah_pkg::S_BIN_RD;
      end
      bsah_pkg::S_SW_RD:   state_next = bsah_pkg::S_SW_GROW;
      bsah_pkg::S_SW_GROW: state_next = bsah_pkg::S_SW_MUL;
      bsah_pkg::S_SW_MUL:  state_next = bsah_pkg::S_SW_AREA;
      bsah_pkg::S_SW_AREA: state_next = bsah_pkg::S_SW_COST;
      bsah_pkg::S_SW_COST: state_next = bsah_pkg::S_SW_NEXT;
      bsah_pkg::S_SW_NEXT: begin
        state_next = (right && bidx == BA'(1)) ? bsah_pkg::S_AX_END : bsah_pkg::S_SW_RD;
      end
      bsah_pkg::S_AX_END: state_next = bsah_pkg::S_AX_START;
      bsah_pkg::S_POS_DIV: state_next = bsah_pkg::S_DONE;
      bsah_pkg::S_DONE: begin
        if (!out_valid) state_next = bsah_pkg::S_LOAD;
      end
      default: state_next = bsah_pkg::S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prim_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == bsah_pkg::S_LOAD && in_acc) begin
        if (is_empty_set) begin
          prim_count <= '0;
          out_valid  <= 1'b1;
        end else if (prim_count < CW'(MAX_PRIMS)) begin
          prim_count <= prim_count + CW'(1);
        end
      end
      if (state == bsah_pkg::S_DONE && !out_valid) begin
        prim_count <= '0;
        out_valid  <= 1'b1;
      end
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      bsah_pkg::S_LOAD: begin
        ptr        <= '0;
        axis       <= bsah_pkg::AXIS_X;
        best_found <= 1'b0;
        best       <= bsah_pkg::COST_MAX;
        best_axis  <= bsah_pkg::AXIS_X;
        if (in_acc && is_empty_set) begin
          found          <= 1'b0;
          split_axis     <= bsah_pkg::AXIS_X;
          split_cost     <= bsah_pkg::COST_MAX;
          split_position <= '0;
        end
      end
      bsah_pkg::S_BND_RD: begin
      end
      bsah_pkg::S_BND_ACC: begin
        for (int k = 0; k < 3; k++) begin
          if (ptr == '0 || pr_cent[k] < b_lo[k]) b_lo[k] <= pr_cent[k];
          if (ptr == '0 || pr_cent[k] > b_hi[k]) b_hi[k] <= pr_cent[k];
        end
        ptr <= ptr + CW'(1);
      end
      bsah_pkg::S_AX_START: begin
        bidx     <= '0;
        ax_found <= 1'b0;
        ptr      <= '0;
        if (axis == bsah_pkg::AXIS_DONE) begin
          div_num <= DW'(best_span) * DW'({1'b0, best_plane} + (BA+1)'(1));
        end else if (cur_deg) begin
          axis <= axis + bsah_pkg::AXIS_W'(1);
        end
      end
      bsah_pkg::S_CLR: begin
        bidx <= bidx + BA'(1);
      end
      bsah_pkg::S_BIN_RD: begin
      end
      bsah_pkg::S_BIN_LD: begin
        div_num <= DW'($unsigned(CB'(cur_cent - cur_lo))) * DW'(BINS);
        div_den <= cur_span;
        div_rem <= '0;
        div_cnt <= DCW'(DW);
      end
      bsah_pkg::S_BIN_DIV: begin
        div_rem <= rem_next;
        div_quo <= {div_quo[DW-2:0], ge};
        div_num <= {div_num[DW-2:0], 1'b0};
        div_cnt <= div_cnt - DCW'(1);
      end
      bsah_pkg::S_POS_DIV: begin
        pos_quo <= pos_prod[POS_SH +: CB];
      end
      bsah_pkg::S_BIN_BRD: begin
      end
      bsah_pkg::S_BIN_UPD: begin
        if (ptr == last_ptr) begin
          bidx  <= '0;
          right <= 1'b0;
          n_acc <= '0;
          for (int k = 0; k < 3; k++) begin
            acc_lo[k] <= C_MAX;
            acc_hi[k] <= C_MIN;
          end
        end else begin
          ptr <= ptr + CW'(1);
        end
      end
      bsah_pkg::S_SW_RD: begin
      end
      bsah_pkg::S_SW_GROW: begin
        for (int k = 0; k < 3; k++) begin
          if (bn_min[k] < acc_lo[k]) acc_lo[k] <= bn_min[k];
          if (bn_max[k] > acc_hi[k]) acc_hi[k] <= bn_max[k];
        end
        n_acc <= n_acc + bn_cnt;
      end
      bsah_pkg::S_SW_MUL: begin
        neg     <= (acc_lo[0] > acc_hi[0]) || (acc_lo[1] > acc_hi[1]) ||
                   (acc_lo[2] > acc_hi[2]);
        prod[0] <= PRW'($unsigned(CB'(acc_hi[0] - acc_lo[0]))) *
                   PRW'($unsigned(CB'(acc_hi[1] - acc_lo[1])));
        prod[1] <= PRW'($unsigned(CB'(acc_hi[1] - acc_lo[1]))) *
                   PRW'($unsigned(CB'(acc_hi[2] - acc_lo[2])));
        prod[2] <= PRW'($unsigned(CB'(acc_hi[0] - acc_lo[0]))) *
                   PRW'($unsigned(CB'(acc_hi[2] - acc_lo[2])));
      end
      bsah_pkg::S_SW_AREA: begin
        area <= neg ? '0 : (AR'(prod[0]) + AR'(prod[1]) + AR'(prod[2])) << 1;
      end
      bsah_pkg::S_SW_COST: begin
        cst <= (|cst_full[PW-1:63]) ? bsah_pkg::COST_MAX : cst_full[62:0];
      end
      bsah_pkg::S_SW_NEXT: begin
        if (!right) begin
          if (bidx == BA'(BINS - 2)) begin
            right <= 1'b1;
            bidx  <= BA'(BINS - 1);
            n_acc <= '0;
            for (int k = 0; k < 3; k++) begin
              acc_lo[k] <= C_MAX;
              acc_hi[k] <= C_MIN;
            end
          end else begin
            bidx <= bidx + BA'(1);
          end
        end else begin
          // Planes run downward here, so an equal cost moves the pick to the lower plane.
          if (!ax_found || total <= ax_best) begin
            ax_found <= 1'b1;
            ax_best  <= total;
            ax_plane <= bidx - BA'(1);
          end
          bidx <= bidx - BA'(1);
        end
      end
      bsah_pkg::S_AX_END: begin
        if (ax_found && (!best_found || ax_best < best)) begin
          best_found <= 1'b1;
          best       <= ax_best;
          best_axis  <= axis;
          best_plane <= ax_plane;
          best_lo    <= cur_lo;
          best_span  <= cur_span;
        end
        axis <= axis + bsah_pkg::AXIS_W'(1);
      end
      bsah_pkg::S_DONE: begin
        if (!out_valid) begin
          found          <= best_found;
          split_axis     <= best_axis;
          split_cost     <= best;
          split_position <= best_found ? bsah_pkg::FIELD_W'(pos_full[CB-1:0]) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    prim_count <= CW'(MAX_PRIMS))
    else $error("primitive count beyond capacity");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == bsah_pkg::S_BIN_DIV |-> div_den != '0)
    else $error("binning divider started on a degenerate axis");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    state == bsah_pkg::S_BIN_RD |-> ptr < prim_count)
    else $error("primitive read beyond stored count");

  a_not_found_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> split_cost == bsah_pkg::COST_MAX)
    else $error("result without split carries a cost");

endmodule

@@ verif/tb_binned_sah_split_finder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binned_sah_split_finder: directed and random primitive sets,
// checked against an in-bench SAH split predictor over a valid/stall interface.
// Depends on bsah_pkg and the block's RTL.
module tb_binned_sah_split_finder;

  localparam int NBINS = bsah_pkg::BINS_DEF;
  localparam int NPRIMS = bsah_pkg::MAX_PRIMS_DEF;
  localparam int FIELD_W = bsah_pkg::FIELD_W;
  localparam int AXIS_W = bsah_pkg::AXIS_W;
  localparam int COST_W = bsah_pkg::COST_W;
  localparam longint unsigned SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0][15:0] mn;
    logic [2:0][15:0] mx;
    logic [2:0][15:0] ct;
  } prim_t;

  typedef struct packed {
    logic found;
    logic [AXIS_W-1:0] axis;
    logic [COST_W-1:0] cost;
    logic [FIELD_W-1:0] pos;
  } split_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FIELD_W-1:0] min_x = '0, min_y = '0, min_z = '0;
  logic signed [FIELD_W-1:0] max_x = '0, max_y = '0, max_z = '0;
  logic signed [FIELD_W-1:0] cent_x = '0, cent_y = '0, cent_z = '0;
  logic is_last = 1'b0;
  logic is_empty_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [AXIS_W-1:0] split_axis;
  logic [COST_W-1:0] split_cost;
  logic signed [FIELD_W-1:0] split_position;

  binned_sah_split_finder dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the stored set of primitives.
  int set_min[NPRIMS][3];
  int set_max[NPRIMS][3];
  int set_cent[NPRIMS][3];
  int set_count = 0;
  split_t split_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
    if (a == 0) return 0;
    if (b > SAT / a) return SAT;
    return a * b;
  endfunction

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > SAT) ? SAT : s;
  endfunction

  function automatic longint unsigned surface(int lx, int ly, int lz, int hx, int hy, int hz);
    longint unsigned dx, dy, dz;
    if (lx > hx || ly > hy || lz > hz) return 0;
    dx = longint'(hx) - longint'(lx);
    dy = longint'(hy) - longint'(ly);
    dz = longint'(hz) - longint'(lz);
    return sat_mul(2, sat_add(sat_add(sat_mul(dx, dy), sat_mul(dy, dz)), sat_mul(dx, dz)));
  endfunction

  function automatic split_t best_split();
    split_t r;
    int bmin[NBINS][3];
    int bmax[NBINS][3];
    int bcnt[NBINS];
    int alo[3];
    int ahi[3];
    longint unsigned lcnt[NBINS], larea[NBINS], rcnt[NBINS], rarea[NBINS];
    longint unsigned n, cost;
    longint lo, hi, span, idx;
    r.found = 1'b0;
    r.axis = bsah_pkg::AXIS_X;
    r.cost = SAT[COST_W-1:0];
    r.pos = '0;
    for (int ax = 0; ax < 3 && set_count > 0; ax++) begin
      lo = set_cent[0][ax];
      hi = lo;
      for (int p = 1; p < set_count; p++) begin
        if (set_cent[p][ax] < lo) lo = set_cent[p][ax];
        if (set_cent[p][ax] > hi) hi = set_cent[p][ax];
      end
      if (lo == hi) continue;
      span = hi - lo;
      for (int b = 0; b < NBINS; b++) begin
        for (int k = 0; k < 3; k++) begin
          bmin[b][k] = 32'h7FFF_FFFF;
          bmax[b][k] = 32'h8000_0000;
        end
        bcnt[b] = 0;
      end
      for (int p = 0; p < set_count; p++) begin
        idx = (longint'(set_cent[p][ax]) - lo) * NBINS / span;
        if (idx > NBINS - 1) idx = NBINS - 1;
        for (int k = 0; k < 3; k++) begin
          if (set_min[p][k] < bmin[idx][k]) bmin[idx][k] = set_min[p][k];
          if (set_max[p][k] > bmax[idx][k]) bmax[idx][k] = set_max[p][k];
        end
        bcnt[idx]++;
      end
      // Left sweep runs over buckets 0..BINS-2, right sweep from the top bucket down.
      for (int k = 0; k < 3; k++) begin
        alo[k] = 32'h7FFF_FFFF;
        ahi[k] = 32'h8000_0000;
      end
      n = 0;
      for (int b = 0; b < NBINS - 1; b++) begin
        n += bcnt[b];
        for (int k = 0; k < 3; k++) begin
          if (bmin[b][k] < alo[k]) alo[k] = bmin[b][k];
          if (bmax[b][k] > ahi[k]) ahi[k] = bmax[b][k];
        end
        lcnt[b] = n;
        larea[b] = surface(alo[0], alo[1], alo[2], ahi[0], ahi[1], ahi[2]);
      end
      for (int k = 0; k < 3; k++) begin
        alo[k] = 32'h7FFF_FFFF;
        ahi[k] = 32'h8000_0000;
      end
      n = 0;
      for (int b = NBINS - 1; b >= 1; b--) begin
        n += bcnt[b];
        for (int k = 0; k < 3; k++) begin
          if (bmin[b][k] < alo[k]) alo[k] = bmin[b][k];
          if (bmax[b][k] > ahi[k]) ahi[k] = bmax[b][k];
        end
        rcnt[b-1] = n;
        rarea[b-1] = surface(alo[0], alo[1], alo[2], ahi[0], ahi[1], ahi[2]);
      end
      for (int b = 0; b < NBINS - 1; b++) begin
        cost = sat_add(sat_mul(lcnt[b], larea[b]), sat_mul(rcnt[b], rarea[b]));
        if (!r.found || cost < {1'b0, r.cost}) begin
          r.found = 1'b1;
          r.cost = cost[COST_W-1:0];
          r.axis = AXIS_W'(ax);
          r.pos = FIELD_W'(lo + span * (b + 1) / NBINS);
        end
      end
    end
    return r;
  endfunction

  function automatic void predict_beat(prim_t p, logic last, logic empty);
    split_t r;
    if (empty) begin
      set_count = 0;
      r.found = 1'b0;
      r.axis = bsah_pkg::AXIS_X;
      r.cost = SAT[COST_W-1:0];
      r.pos = '0;
      split_q = {split_q, r};
      return;
    end
    if (set_count < NPRIMS) begin
      for (int k = 0; k < 3; k++) begin
        set_min[set_count][k] = $signed(p.mn[k]);
        set_max[set_count][k] = $signed(p.mx[k]);
        set_cent[set_count][k] = $signed(p.ct[k]);
      end
      set_count++;
    end
    if (last) begin
      split_q = {split_q, best_split()};
      set_count = 0;
    end
  endfunction

  task automatic send_beat(prim_t p, logic last, logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {min_z, min_y, min_x} <= p.mn;
    {max_z, max_y, max_x} <= p.mx;
    {cent_z, cent_y, cent_x} <= p.ct;
    is_last <= last;
    is_empty_set <= empty;
    do @(posedge clk); while (in_stall);
    predict_beat(p, last, empty);
  endtask

  function automatic prim_t random_prim(int spread);
    prim_t p;
    for (int k = 0; k < 3; k++) begin
      if (spread == 0) begin
        p.mn[k] = 16'($urandom);
        p.mx[k] = 16'($urandom);
        p.ct[k] = 16'($urandom);
      end else begin
        p.ct[k] = 16'($urandom_range(spread) - spread / 2);
        p.mn[k] = p.ct[k] - 16'($urandom_range(spread));
        p.mx[k] = p.ct[k] + 16'($urandom_range(spread));
      end
    end
    return p;
  endfunction

  task automatic send_set(int len, int spread);
    for (int i = 0; i < len; i++) send_beat(random_prim(spread), i == len - 1, 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (split_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Receiver: drives out_stall and checks each result beat against the oldest expected split.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (split_q.size() == 0) begin
          $display("%0t: result with none expected: found=%0b axis=%0d cost=%0d pos=%0d",
                   $time, found, split_axis, split_cost, split_position);
          errors++;
        end else begin
          split_t e;
          e = split_q.pop_front();
          if (found !== e.found) begin
            $display("%0t: found expected %0b actual %0b", $time, e.found, found);
            errors++;
          end
          if (split_axis !== e.axis) begin
            $display("%0t: split_axis expected %0d actual %0d", $time, e.axis, split_axis);
            errors++;
          end
          if (split_cost !== e.cost) begin
            $display("%0t: split_cost expected %0d actual %0d", $time, e.cost, split_cost);
            errors++;
          end
          if (split_position !== e.pos) begin
            $display("%0t: split_position expected %0d actual %0d", $time,
                     $signed(e.pos), split_position);
            errors++;
          end
        end
      end
      if (hold_go) begin
        hold_left <= 600;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_extremes();
    prim_t p;
    p.mn = {3{16'h8000}};
    p.mx = {3{16'h7FFF}};
    p.ct = {3{16'h8000}};
    send_beat(p, 1'b0, 1'b0);
    p.ct = {3{16'h7FFF}};
    send_beat(p, 1'b0, 1'b0);
    p.ct = {3{16'h0000}};
    send_beat(p, 1'b1, 1'b0);
    // Inverted boxes give zero area.
    p.mn = {3{16'h7FFF}};
    p.mx = {3{16'h8000}};
    p.ct = {16'h0001, 16'hFFFF, 16'h8000};
    send_beat(p, 1'b0, 1'b0);
    p.ct = {16'hFFFE, 16'h0000, 16'h7FFF};
    send_beat(p, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_degenerate();
    prim_t p;
    // Single primitive, then all centroids equal: no axis qualifies.
    send_beat(random_prim(0), 1'b1, 1'b0);
    p = random_prim(0);
    for (int i = 0; i < 4; i++) begin
      p.mn = {16'($urandom), 32'($urandom)};
      send_beat(p, i == 3, 1'b0);
    end
    // Only z varies, so x and y are skipped.
    for (int i = 0; i < 5; i++) begin
      p.ct[2] = 16'(i * 100);
      send_beat(p, i == 4, 1'b0);
    end
    drain();
  endtask

  task automatic test_empty_set();
    send_beat(random_prim(0), 1'b0, 1'b1);
    send_beat(random_prim(0), 1'b1, 1'b1);
    send_beat(random_prim(300), 1'b0, 1'b0);
    send_beat(random_prim(300), 1'b0, 1'b0);
    send_beat(random_prim(300), 1'b0, 1'b1);
    send_set(3, 300);
    drain();
  endtask

  task automatic test_ties();
    prim_t p;
    // Mirror-image primitives give equal costs on many planes and on all axes.
    for (int i = 0; i < 4; i++) begin
      p.ct = {3{16'(i * 16)}};
      p.mn = {3{16'(i * 16 - 2)}};
      p.mx = {3{16'(i * 16 + 2)}};
      send_beat(p, i == 3, 1'b0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int s = 0; s < 4; s++) send_set(3, 1000);
    drain();
  endtask

  task automatic test_random(int beats);
    int sent;
    int len;
    int spread;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) == 0) begin
        send_beat(random_prim(0), 1'($urandom_range(1)), 1'b1);
        sent++;
      end else begin
        len = $urandom_range(12, 1);
        case ($urandom_range(3))
          0: spread = 0;
          1: spread = 8;
          2: spread = 200;
          default: spread = 20000;
        endcase
        send_set(len, spread);
        sent += len;
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_degenerate();
    test_empty_set();
    test_ties();
    test_backpressure();
    send_idle_pct = 33;
    recv_idle_pct = 51;
    test_random(150);
    send_idle_pct = 51;
    recv_idle_pct = 33;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    repeat (200) @(posedge clk);
    if (errors == 0 && split_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
